[src/clpf_pkg.sv]
// Package for the command line packet framer: payload types, characters and defaults.
`default_nettype none

package clpf_pkg;

  // Default geometry of the receive buffers and the descriptor ring.
  localparam int unsigned BUFFER_BYTES_DEF     = 256;
  localparam int unsigned MAX_PACKET_BYTES_DEF = 32;
  localparam int unsigned RING_SLOTS_DEF       = 8;

  // Characters that matter to the framer.
  localparam logic [7:0] CHAR_SEMI    = 8'h3B;
  localparam logic [7:0] CHAR_CR      = 8'h0D;
  localparam logic [7:0] CHAR_LF      = 8'h0A;
  localparam logic [7:0] CHAR_LOWER_A = 8'h61;
  localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;
  localparam logic [7:0] CASE_OFFSET  = 8'd32;

  // Configuration register indexes and reset values.
  localparam logic [0:0] CFG_TAG_CHAN0 = 1'b0;
  localparam logic [0:0] CFG_TAG_CHAN1 = 1'b1;
  localparam logic [7:0] TAG_CHAN0_RST = 8'd1;
  localparam logic [7:0] TAG_CHAN1_RST = 8'd2;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       rx_channel;
  } clpf_in_t;

  typedef struct packed {
    logic       write_channel;
    logic [7:0] byte_address;
    logic [7:0] byte_value;
    logic       packet_end;
    logic [7:0] tag_address;
    logic [7:0] tag_value;
    logic [7:0] packet_start_address;
    logic [2:0] packet_slot;
    logic [7:0] packet_total;
  } clpf_out_t;

endpackage

`default_nettype wire

[src/command_line_packet_framer.sv]
// Top level of the command line packet framer: pointer update and result register.
`default_nettype none

// Command line packet framer for two receive channels.
// Input channel (in_valid_i / in_ready_o / in_data_i): one request carries a received
// byte and the channel number that delivered it. Output channel (out_valid_o /
// out_ready_i / out_data_o): one request per input request, giving the buffer write of
// the converted byte and, when the byte was a ';', CR or LF, the tag write, the start
// of the finished packet and its descriptor ring slot, and always the packet count.
// An accepted request is registered and appears on the output in the next cycle.
// Throughput is one request per cycle while the receiver takes the results; the
// per-channel pointers, ring slot and counter are updated in the same cycle as the
// request is accepted, so consecutive requests on the same channel follow with no gap.
// The output register decouples the two sides: a new request is taken whenever the
// register is empty or its contents are taken in the same cycle. If the receiver
// stalls, one result is held and the input stalls until it drains.
// The configuration port writes the two tag bytes; writes take effect at once. The user
// makes them only while the block is idle; the block itself does not enforce this.
// Reset clears both write pointers, both packet start pointers, the ring slot and the
// packet counter, sets the tags to 1 and 2, and empties the output register.
module command_line_packet_framer #(
  parameter int unsigned BUFFER_BYTES     = clpf_pkg::BUFFER_BYTES_DEF,
  parameter int unsigned MAX_PACKET_BYTES = clpf_pkg::MAX_PACKET_BYTES_DEF,
  parameter int unsigned RING_SLOTS       = clpf_pkg::RING_SLOTS_DEF
) (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 cfg_we_i,
  input  wire  [0:0]          cfg_addr_i,
  input  wire  [7:0]          cfg_wdata_i,
  input  wire                 in_valid_i,
  output logic                in_ready_o,
  input  clpf_pkg::clpf_in_t  in_data_i,
  output logic                out_valid_o,
  input  wire                 out_ready_i,
  output clpf_pkg::clpf_out_t out_data_o
);

  // Pointer width, ring slot width, and widths used to report them as 8 or 3 bit fields.
  localparam int unsigned PW  = $clog2(BUFFER_BYTES);
  localparam int unsigned RW  = $clog2(RING_SLOTS);
  localparam int unsigned AXW = (PW > 8) ? PW : 8;
  localparam int unsigned SXW = (RW > 3) ? RW : 3;
  // Width for the restart test, wide enough for pointer + 2 + maximum packet size.
  localparam int unsigned CW  = $clog2(BUFFER_BYTES + MAX_PACKET_BYTES + 2) + 1;

  logic [PW-1:0] wr_ptr_q    [2];
  logic [PW-1:0] start_ptr_q [2];
  logic [RW-1:0] slot_q;
  logic [7:0]    count_q;
  logic [7:0]    tag0_q;
  logic [7:0]    tag1_q;
  logic          out_valid_q;
  clpf_pkg::clpf_out_t out_q;

  logic          in_acc;
  logic          ch;
  logic [7:0]    rx_b;
  logic [7:0]    conv;
  logic          is_term;
  logic [PW-1:0] wp;
  logic [PW:0]   wp_inc;
  logic [PW-1:0] wp_wrap;
  logic [CW-1:0] restart_sum;
  logic [CW-1:0] wp_plus2;
  logic          fits;
  logic [PW-1:0] next_start;
  logic [PW-1:0] start_cur;
  logic [RW-1:0] slot_next;
  logic [7:0]    count_d;
  logic [AXW-1:0] wp_ext;
  logic [AXW-1:0] tag_ext;
  logic [AXW-1:0] start_ext;
  logic [SXW-1:0] slot_ext;
  clpf_pkg::clpf_out_t out_d;

  // The output register is free when empty or when its result leaves this cycle.
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_acc     = in_valid_i && in_ready_o;

  assign ch   = in_data_i.rx_channel;
  assign rx_b = in_data_i.rx_byte;

  // Lowercase letters are raised to uppercase; everything else passes unchanged.
  assign conv = (rx_b >= clpf_pkg::CHAR_LOWER_A && rx_b <= clpf_pkg::CHAR_LOWER_Z)
                ? rx_b - clpf_pkg::CASE_OFFSET : rx_b;
  assign is_term = (conv == clpf_pkg::CHAR_SEMI) || (conv == clpf_pkg::CHAR_CR) ||
                   (conv == clpf_pkg::CHAR_LF);

  assign wp        = wr_ptr_q[ch];
  assign start_cur = start_ptr_q[ch];

  // Next buffer position, wrapping at the buffer end; it is also the tag position.
  assign wp_inc  = {1'b0, wp} + (PW+1)'(1);
  assign wp_wrap = (wp_inc == (PW+1)'(BUFFER_BYTES)) ? '0 : wp_inc[PW-1:0];

  // The next packet starts after the tag, unless a packet of maximum size would then
  // run past the buffer end, in which case it starts at position zero.
  assign wp_plus2    = CW'(wp) + CW'(2);
  assign restart_sum = wp_plus2 + CW'(MAX_PACKET_BYTES);
  assign fits        = restart_sum < CW'(BUFFER_BYTES);
  assign next_start  = fits ? wp_plus2[PW-1:0] : '0;

  assign slot_next = (slot_q == RW'(RING_SLOTS - 1)) ? '0 : slot_q + RW'(1);
  assign count_d   = is_term ? count_q + 8'd1 : count_q;

  assign wp_ext    = AXW'(wp);
  assign tag_ext   = AXW'(wp_wrap);
  assign start_ext = AXW'(start_cur);
  assign slot_ext  = SXW'(slot_q);

  always_comb begin
    out_d                      = '0;
    out_d.write_channel        = ch;
    out_d.byte_address         = wp_ext[7:0];
    out_d.byte_value           = conv;
    out_d.packet_end           = is_term;
    out_d.packet_total         = count_d;
    if (is_term) begin
      out_d.tag_address          = tag_ext[7:0];
      out_d.tag_value            = ch ? tag1_q : tag0_q;
      out_d.packet_start_address = start_ext[7:0];
      out_d.packet_slot          = slot_ext[2:0];
    end
  end

  // Framing state. The descriptor written to the ring slot is the packet start and
  // channel, which leave on the output channel with the slot number, so the ring
  // itself needs no storage in this block.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q[0]    <= '0;
      wr_ptr_q[1]    <= '0;
      start_ptr_q[0] <= '0;
      start_ptr_q[1] <= '0;
      slot_q         <= '0;
      count_q        <= '0;
    end else if (in_acc) begin
      count_q <= count_d;
      if (is_term) begin
        wr_ptr_q[ch]    <= next_start;
        start_ptr_q[ch] <= next_start;
        slot_q          <= slot_next;
      end else begin
        wr_ptr_q[ch] <= wp_wrap;
      end
    end
  end

  // Tag registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag0_q <= clpf_pkg::TAG_CHAN0_RST;
      tag1_q <= clpf_pkg::TAG_CHAN1_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        clpf_pkg::CFG_TAG_CHAN0: tag0_q <= cfg_wdata_i;
        clpf_pkg::CFG_TAG_CHAN1: tag1_q <= cfg_wdata_i;
      endcase
    end
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_acc) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef SYNTHESIS
  // An accepted request always leaves a result in the output register.
  a_acc_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> out_valid_o)
    else $error("accepted request produced no result");

  // A held result blocks the input side.
  a_stall_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |-> !in_ready_o)
    else $error("input accepted while result stalled");

  // Without a packet end the packet fields read zero.
  a_no_end_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_data_o.packet_end) |->
      (out_data_o.tag_address == 8'd0 && out_data_o.packet_slot == 3'd0 &&
       out_data_o.packet_start_address == 8'd0 && out_data_o.tag_value == 8'd0))
    else $error("packet fields set without packet end");

  // A packet start is either zero or leaves room for a packet of maximum size.
  a_start_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((start_ptr_q[0] == '0) ||
     (CW'(start_ptr_q[0]) + CW'(MAX_PACKET_BYTES) < CW'(BUFFER_BYTES))) &&
    ((start_ptr_q[1] == '0) ||
     (CW'(start_ptr_q[1]) + CW'(MAX_PACKET_BYTES) < CW'(BUFFER_BYTES))))
    else $error("packet start leaves no room for a full packet");
`endif

endmodule

`default_nettype wire
